@@ src/bezier_de_casteljau_sweep_core_assert.svh @@
// Assertion macros for the Bezier sweep core.
// Included by the sweep core, which checks its own sequencing; needs i_clk and i_rst_n in scope.
`ifndef BEZIER_DE_CASTELJAU_SWEEP_CORE_ASSERT_SVH
`define BEZIER_DE_CASTELJAU_SWEEP_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BDC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bdc: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define BDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bdc: next-cycle check failed");

`endif

@@ src/bdc_pkg.sv @@
// Shared types and constants of the Bezier sweep core.
// No dependencies; imported by every module of the block.
package bdc_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 24;
    localparam int T_W        = 16;
    localparam int PCNT_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_T_INCREMENT = 1'd1;

    typedef struct packed {
        logic                       action;
        logic [3:0]                 point_index;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0]  curve_x;
        logic signed [COORD_W-1:0]  curve_y;
        logic                       sweep_last;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic             ctrl_we;
        logic [IDX_W-1:0] ctrl_addr;
        logic             work_we;
        logic [IDX_W-1:0] work_addr;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } t_mem_ctl;

    typedef struct packed {
        logic sub_en;
        logic mul_en;
    } t_lerp_ctl;

endpackage

@@ src/bdc_point_mem.sv @@
// Control point store and interpolation scratch store of the Bezier sweep core.
// Depends on bdc_pkg; both arrays share one read address and have registered read data.
module bdc_point_mem
    import bdc_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_ctl i_ctl,
    input  t_point   i_ctrl_wdata,
    input  t_point   i_work_wdata,
    output t_point   o_ctrl_rdata,
    output t_point   o_work_rdata
);

    t_point r_ctrl_mem [MAX_POINTS];
    t_point r_work_mem [MAX_POINTS];
    t_point r_ctrl_q;
    t_point r_work_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ctrl_we) begin
            r_ctrl_mem[i_ctl.ctrl_addr] <= i_ctrl_wdata;
        end
        if (i_ctl.work_we) begin
            r_work_mem[i_ctl.work_addr] <= i_work_wdata;
        end
        // Read data holds between reads, so the sequencer may use it until the next read.
        if (i_ctl.rd_en) begin
            r_ctrl_q <= r_ctrl_mem[i_ctl.rd_addr];
            r_work_q <= r_work_mem[i_ctl.rd_addr];
        end
    end

    assign o_ctrl_rdata = r_ctrl_q;
    assign o_work_rdata = r_work_q;

endmodule

@@ src/bdc_lerp.sv @@
// Shared interpolation unit: a + round((b - a) * t), one coordinate at a time.
// Depends on bdc_pkg; subtract and multiply are registered steps under sequencer control.
module bdc_lerp
    import bdc_pkg::*;
(
    input  logic               i_clk,
    input  t_lerp_ctl          i_ctl,
    input  logic [COORD_W-1:0] i_a,
    input  logic [COORD_W-1:0] i_b,
    input  logic [T_W-1:0]     i_t,
    output logic [COORD_W-1:0] o_result
);

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + T_W + 1;

    logic signed [DIFF_W-1:0] r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] w_round;

    always_ff @(posedge i_clk) begin
        if (i_ctl.sub_en) begin
            r_diff <= signed'({i_b[COORD_W-1], i_b}) - signed'({i_a[COORD_W-1], i_a});
        end
        if (i_ctl.mul_en) begin
            r_prod <= PROD_W'(r_diff * signed'({1'b0, i_t}));
        end
    end

    // Round to nearest with ties upward; the arithmetic shift is a floor division.
    assign w_round  = r_prod + PROD_W'(signed'(33'sd32768));
    assign o_result = i_a + w_round[T_W+COORD_W-1:T_W];

endmodule

@@ src/bezier_de_casteljau_sweep_core.sv @@
// Bezier curve sweep by de Casteljau interpolation over stored control points.
// Depends on bdc_pkg, bdc_point_mem, bdc_lerp and the assertion macro header.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): a load transaction writes one
// control point and leaves the core idle, producing no result. A step transaction
// evaluates the curve at the current t, then advances t by t_increment; the step
// whose advance reaches one is flagged sweep_last and t restarts from zero.
// Output channel (o_out_valid / i_out_stall / o_out_data): one transaction per step.
// A step with n points in use reads the first two points of each level, then runs the
// n(n-1)/2 interpolations (subtract, multiply, add for x then y on the one shared
// multiplier) and hands the finished point over to the output register.
// o_in_stall is high while a step is being worked on.
// The finished point waits in an output register; a stalled receiver holds that
// register, and a further step finishes its work then waits until the register frees.
// Synchronous reset returns point_count to 4, t_increment to 7 and t to zero; the
// control point store is not cleared and must be loaded before the first step. The user
// must write configuration via i_cfg_we / i_cfg_index / i_cfg_data only while idle; the block does not enforce it.
module bezier_de_casteljau_sweep_core
    import bdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    `include "bezier_de_casteljau_sweep_core_assert.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RDA  = 3'd1;
    localparam logic [2:0] ST_RDB  = 3'd2;
    localparam logic [2:0] ST_SUB  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_ADD  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]         r_state;
    logic [PCNT_W-1:0]  r_point_count;
    logic [T_W-1:0]     r_t_inc;
    logic [T_W-1:0]     r_sweep_t;
    logic [T_W-1:0]     r_t;
    logic               r_last;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_level;
    logic [CNT_W-1:0]   r_j;
    logic               r_coord;
    t_point             r_a;
    logic [COORD_W-1:0] r_res_x;
    logic [COORD_W-1:0] r_res_y;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               w_accept;
    logic               w_more_pairs;
    logic               w_level_end;
    logic               w_out_free;
    logic [T_W:0]       n_sweep_t;
    logic [CNT_W-1:0]   n_count;
    t_mem_ctl           w_mem_ctl;
    t_lerp_ctl          w_lerp_ctl;
    t_point             w_ctrl_wdata;
    t_point             w_work_wdata;
    t_point             w_ctrl_rdata;
    t_point             w_work_rdata;
    t_point             w_b;
    logic [COORD_W-1:0] w_a_c;
    logic [COORD_W-1:0] w_b_c;
    logic [COORD_W-1:0] w_lerp;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Point count clamped to the supported range.
    always_comb begin
        if (r_point_count < PCNT_W'(2)) begin
            n_count = CNT_W'(2);
        end else if (r_point_count > PCNT_W'(MAX_POINTS)) begin
            n_count = CNT_W'(MAX_POINTS);
        end else begin
            n_count = CNT_W'(r_point_count);
        end
    end

    assign n_sweep_t = {1'b0, r_sweep_t} + {1'b0, r_t_inc};

    // The first level reads control points, later levels the scratch store.
    assign w_b   = (r_level == CNT_W'(1)) ? w_ctrl_rdata : w_work_rdata;
    assign w_a_c = r_coord ? r_a.y : r_a.x;
    assign w_b_c = r_coord ? w_b.y : w_b.x;

    assign w_more_pairs = (r_j + CNT_W'(1) + r_level) < r_n;
    assign w_level_end  = (r_level + CNT_W'(1)) == r_n;

    always_comb begin
        w_mem_ctl           = '0;
        w_mem_ctl.ctrl_we   = w_accept && (i_in_data.action == ACT_LOAD)
                              && ({1'b0, i_in_data.point_index} < 5'(MAX_POINTS));
        w_mem_ctl.ctrl_addr = IDX_W'(i_in_data.point_index);
        w_mem_ctl.work_we   = (r_state == ST_ADD) && r_coord;
        w_mem_ctl.work_addr = r_j[IDX_W-1:0];
        case (r_state)
            ST_RDA: begin
                w_mem_ctl.rd_en   = 1'b1;
                w_mem_ctl.rd_addr = '0;
            end
            ST_RDB: begin
                w_mem_ctl.rd_en   = 1'b1;
                w_mem_ctl.rd_addr = IDX_W'(1);
            end
            ST_ADD: begin
                w_mem_ctl.rd_en   = r_coord && w_more_pairs;
                w_mem_ctl.rd_addr = IDX_W'(r_j + CNT_W'(2));
            end
            default: begin
                w_mem_ctl.rd_en   = 1'b0;
            end
        endcase
    end

    assign w_lerp_ctl.sub_en = (r_state == ST_SUB);
    assign w_lerp_ctl.mul_en = (r_state == ST_MUL);

    assign w_ctrl_wdata.x = i_in_data.point_x;
    assign w_ctrl_wdata.y = i_in_data.point_y;
    assign w_work_wdata.x = r_res_x;
    assign w_work_wdata.y = w_lerp;

    bdc_point_mem u_mem (
        .i_clk        (i_clk),
        .i_ctl        (w_mem_ctl),
        .i_ctrl_wdata (w_ctrl_wdata),
        .i_work_wdata (w_work_wdata),
        .o_ctrl_rdata (w_ctrl_rdata),
        .o_work_rdata (w_work_rdata)
    );

    bdc_lerp u_lerp (
        .i_clk    (i_clk),
        .i_ctl    (w_lerp_ctl),
        .i_a      (w_a_c),
        .i_b      (w_b_c),
        .i_t      (r_t),
        .o_result (w_lerp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_point_count <= PCNT_W'(4);
            r_t_inc       <= T_W'(7);
            r_sweep_t     <= '0;
            r_out_valid   <= 1'b0;
            r_level       <= '0;
            r_j           <= '0;
            r_n           <= '0;
            r_coord       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_POINT_COUNT: r_point_count <= i_cfg_data[PCNT_W-1:0];
                    REG_T_INCREMENT: r_t_inc       <= i_cfg_data[T_W-1:0];
                    default: ;
                endcase
            end

            // In the hand-over state the register is refilled below instead.
            if (r_out_valid && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept && (i_in_data.action == ACT_STEP)) begin
                        r_t       <= r_sweep_t;
                        r_last    <= n_sweep_t[T_W];
                        r_sweep_t <= n_sweep_t[T_W] ? '0 : n_sweep_t[T_W-1:0];
                        r_n       <= n_count;
                        r_level   <= CNT_W'(1);
                        r_j       <= '0;
                        r_state   <= ST_RDA;
                    end
                end
                ST_RDA: begin
                    r_state <= ST_RDB;
                end
                ST_RDB: begin
                    r_a     <= w_b;
                    r_coord <= 1'b0;
                    r_state <= ST_SUB;
                end
                ST_SUB: begin
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    if (!r_coord) begin
                        r_res_x <= w_lerp;
                        r_coord <= 1'b1;
                        r_state <= ST_SUB;
                    end else begin
                        r_res_y <= w_lerp;
                        r_coord <= 1'b0;
                        if (w_more_pairs) begin
                            // The right-hand point of this pair is the left one of the next.
                            r_a     <= w_b;
                            r_j     <= r_j + CNT_W'(1);
                            r_state <= ST_SUB;
                        end else if (w_level_end) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_level <= r_level + CNT_W'(1);
                            r_j     <= '0;
                            r_state <= ST_RDA;
                        end
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out.curve_x    <= r_res_x;
                        r_out.curve_y    <= r_res_y;
                        r_out.sweep_last <= r_last;
                        r_out_valid      <= 1'b1;
                        r_state          <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BDC_ASSERT_NEXT(a_step_starts, w_accept && (i_in_data.action == ACT_STEP), r_state == ST_RDA)
    `BDC_ASSERT_IMPL(a_pair_in_range, r_state == ST_SUB, (r_j + r_level) < r_n)
    `BDC_ASSERT_IMPL(a_level_in_range, r_state == ST_RDA, (r_level < r_n) && (r_j == '0))
    `BDC_ASSERT_NEXT(a_done_delivers, (r_state == ST_DONE) && w_out_free,
        r_out_valid && (r_state == ST_IDLE))

endmodule

@@ dv/tb.sv @@
// Testbench for bezier_de_casteljau_sweep_core: checks every curve point against
// a behavioural de Casteljau predictor under random sender gaps and receiver stalls.
// Depends on bdc_pkg and the core RTL only.
module tb;
    import bdc_pkg::*;

    localparam int STALL_LIMIT  = 10000;
    localparam int RANDOM_ITEMS = 1120;
    localparam int SETTLE_TAIL  = 1000;

    typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_HEAVY, RX_HOLD} rx_mode_e;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;

    // Predictor state.
    logic signed [COORD_W-1:0] ctrl_x [MAX_POINTS];
    logic signed [COORD_W-1:0] ctrl_y [MAX_POINTS];
    logic [PCNT_W-1:0]         curve_points_cfg;
    logic [T_W-1:0]            t_step_cfg;
    logic [T_W-1:0]            sweep_param;
    t_out_item                 expected_points [$];

    int       mismatches = 0;
    int       burst_left = 0;
    int       stall_run  = 0;
    rx_mode_e stall_mode = RX_FLOW;

    bezier_de_casteljau_sweep_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // One interpolation step, rounded to nearest with ties upward.
    function automatic logic signed [COORD_W-1:0] interp(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic [T_W-1:0]            t
    );
        longint prod;
        prod = (longint'(b) - longint'(a)) * longint'(t) + 32768;
        return COORD_W'(longint'(a) + (prod >>> 16));
    endfunction

    function automatic void evaluate_curve_item(input t_in_item item);
        logic signed [COORD_W-1:0] wx [MAX_POINTS];
        logic signed [COORD_W-1:0] wy [MAX_POINTS];
        logic [T_W:0]              next_t;
        t_out_item                 point;
        int                        n;
        if (item.action == ACT_LOAD) begin
            ctrl_x[item.point_index] = item.point_x;
            ctrl_y[item.point_index] = item.point_y;
            return;
        end
        n = (curve_points_cfg < 2) ? 2 :
            (curve_points_cfg > MAX_POINTS) ? MAX_POINTS : int'(curve_points_cfg);
        for (int j = 0; j < n; j++) begin
            wx[j] = ctrl_x[j];
            wy[j] = ctrl_y[j];
        end
        for (int lvl = 1; lvl < n; lvl++) begin
            for (int j = 0; j + lvl < n; j++) begin
                wx[j] = interp(wx[j], wx[j + 1], sweep_param);
                wy[j] = interp(wy[j], wy[j + 1], sweep_param);
            end
        end
        next_t           = {1'b0, sweep_param} + {1'b0, t_step_cfg};
        point.curve_x    = wx[0];
        point.curve_y    = wy[0];
        point.sweep_last = next_t[T_W];
        sweep_param      = next_t[T_W] ? '0 : next_t[T_W-1:0];
        expected_points.push_back(point);
    endfunction

    // Follow configuration writes and accepted input transactions.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            curve_points_cfg = PCNT_W'(4);
            t_step_cfg       = T_W'(7);
            sweep_param      = '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_POINT_COUNT)
                    curve_points_cfg = i_cfg_data[PCNT_W-1:0];
                else if (i_cfg_index == REG_T_INCREMENT)
                    t_step_cfg = i_cfg_data[T_W-1:0];
            end
            if (i_in_valid && !o_in_stall)
                evaluate_curve_item(i_in_data);
        end
    end

    // Compare each output transaction with the oldest pending curve point.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point x=%h y=%h last=%b with nothing pending",
                             o_out_data.curve_x, o_out_data.curve_y, o_out_data.sweep_last);
            end else begin
                want = expected_points.pop_front();
                if (o_out_data.curve_x !== want.curve_x || o_out_data.curve_y !== want.curve_y
                        || o_out_data.sweep_last !== want.sweep_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("point mismatch: expected x=%h y=%h last=%b, got x=%h y=%h last=%b",
                                 want.curve_x, want.curve_y, want.sweep_last,
                                 o_out_data.curve_x, o_out_data.curve_y,
                                 o_out_data.sweep_last);
                end
            end
        end
    end

    // Receiver back-pressure: free flow, coin tosses, heavy stalling and solid holds.
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode  <= rx_mode_e'($urandom_range(0, 3));
            stall_run   <= $urandom_range(5, 120);
            i_out_stall <= 1'b0;
        end else begin
            stall_run <= stall_run - 1;
            case (stall_mode)
                RX_FLOW:  i_out_stall <= 1'b0;
                RX_COIN:  i_out_stall <= 1'($urandom_range(0, 1));
                RX_HEAVY: i_out_stall <= ($urandom_range(0, 4) != 0);
                default:  i_out_stall <= (stall_run <= 30);
            endcase
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic send_item(input t_in_item item);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Hold the sender off until every pending point has come back. Loads leave no
    // trace on the output, so the task idles on afterwards to let the last one settle.
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(input logic action, input int idx,
                                           input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] y);
        t_in_item item;
        item.action      = action;
        item.point_index = 4'(idx);
        item.point_x     = x;
        item.point_y     = y;
        return item;
    endfunction

    function automatic logic [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 7))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2:       return COORD_W'($urandom_range(0, 1023)) - 24'd512;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    task automatic send_step();
        send_item(make_item(ACT_STEP, $urandom_range(0, 15), random_coord(),
                            random_coord()));
    endtask

    // Every slot is filled first, so no later step reads an unloaded point.
    task automatic load_all_points();
        for (int idx = 0; idx < MAX_POINTS; idx++)
            send_item(make_item(ACT_LOAD, idx, idx[0] ? 24'h800000 : 24'h7FFFFF,
                                idx[1] ? 24'h7FFFFF : 24'h800000));
    endtask

    task automatic test_reset_config();
        repeat (2) send_step();
    endtask

    task automatic test_two_point_line();
        wait_results_done();
        write_reg(REG_POINT_COUNT, CFG_DATA_W'(2));
        write_reg(REG_T_INCREMENT, CFG_DATA_W'(65535));
        repeat (2) send_step();
    endtask

    // Counts below two act as two, counts above the store size as the full store.
    task automatic test_count_clamping();
        wait_results_done();
        write_reg(REG_POINT_COUNT, CFG_DATA_W'(0));
        send_step();
        wait_results_done();
        write_reg(REG_POINT_COUNT, CFG_DATA_W'(31));
        send_step();
    endtask

    task automatic test_zero_increment();
        wait_results_done();
        write_reg(REG_T_INCREMENT, '0);
        send_step();
    endtask

    task automatic test_full_sweep();
        wait_results_done();
        write_reg(REG_POINT_COUNT, CFG_DATA_W'(3));
        write_reg(REG_T_INCREMENT, CFG_DATA_W'(16384));
        repeat (4) send_step();
    endtask

    task automatic test_random_sweeps();
        int sent;
        int phase_len;
        int pc;
        int t_inc;
        t_in_item item;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_results_done();
            case ($urandom_range(0, 11))
                0:       pc = MAX_POINTS;
                1:       pc = $urandom_range(0, 1);
                2:       pc = $urandom_range(17, 31);
                3:       pc = $urandom_range(7, 12);
                default: pc = $urandom_range(2, 6);
            endcase
            case ($urandom_range(0, 9))
                0:       t_inc = 65535;
                1:       t_inc = 1;
                2:       t_inc = 0;
                3:       t_inc = $urandom_range(0, 65535);
                default: t_inc = $urandom_range(2000, 20000);
            endcase
            write_reg(REG_POINT_COUNT, CFG_DATA_W'(pc));
            write_reg(REG_T_INCREMENT, CFG_DATA_W'(t_inc));
            // Wide curves are slow, so their phases are kept short.
            phase_len = (pc > 8) ? $urandom_range(20, 40) : $urandom_range(40, 120);
            repeat (phase_len) begin
                if ($urandom_range(0, 59) == 0)
                    wait_results_done();
                item = make_item(($urandom_range(0, 99) < 40) ? ACT_LOAD : ACT_STEP,
                                 $urandom_range(0, 15), random_coord(), random_coord());
                send_item(item);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        load_all_points();
        test_reset_config();
        test_two_point_line();
        test_count_clamping();
        test_zero_increment();
        test_full_sweep();
        test_random_sweeps();
        wait_results_done();
        repeat (SETTLE_TAIL) @(posedge i_clk);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+src
src/bdc_pkg.sv
src/bdc_point_mem.sv
src/bdc_lerp.sv
src/bezier_de_casteljau_sweep_core.sv
dv/tb.sv
